// ===== rtl/lsr_pkg.sv =====
// Shared types and constants for the linear set-point ramp generator.
`default_nettype none

package lsr_pkg;

	// Field widths
	localparam int unsigned VAL_W   = 32;  // Q16.16 value
	localparam int unsigned TIME_W  = 16;  // ramp time, sample period, tick count
	localparam int unsigned FRAC_W  = 16;  // extra fraction bits below Q16.16
	localparam int unsigned DIFF_W  = VAL_W + 1;            // target - start
	localparam int unsigned STEP_W  = DIFF_W + FRAC_W;      // signed step, Q.32
	localparam int unsigned ACC_W   = STEP_W + 1;           // running sum width

	// Shared serial divider
	localparam int unsigned DVD_W   = STEP_W;               // dividend / quotient
	localparam int unsigned DIV_W   = TIME_W;               // divisor
	localparam int unsigned ITER_W  = $clog2(DVD_W + 1);    // iteration count

	// Iterations for the two divisions
	localparam logic [ITER_W-1:0] CNT_ITERS  = ITER_W'(TIME_W);
	localparam logic [ITER_W-1:0] STEP_ITERS = ITER_W'(DVD_W);

	// Sample period after reset
	localparam logic [TIME_W-1:0] SAMPLE_PERIOD_RST = TIME_W'(1);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CNT,
		ST_STEP,
		ST_FINISH
	} lsr_state_t;

	// Divider launch command
	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} div_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lsr_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module lsr_div
	import lsr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_cmd_t         cmd,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);

	logic [DVD_W-1:0]  dvd_q;     // dividend bits shift out the top, quotient in at bottom
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_W:0]    shifted;
	logic [DIV_W+1:0]  trial;
	logic              ge;
	logic [DIV_W-1:0]  rem_next;

	// Trial subtract for one bit
	always_comb begin
		shifted  = {rem_q, dvd_q[DVD_W-1]};
		trial    = {1'b0, shifted} - {2'b00, dsr_q};
		ge       = ~trial[DIV_W+1];
		rem_next = ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q  <= cmd.iters;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - ITER_W'(1);
			if (cnt_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial remainder
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	// Checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("divider done without a run");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q)
		else $error("divider done while busy");

	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

// ===== rtl/linear_setpoint_ramp.sv =====
// Top level of the linear set-point ramp generator.
`default_nettype none

// Linear set-point ramp generator. Each input transfer is one sample tick and yields one
// ramp_value transfer. When target differs from the target of the latest ramp, a new
// ramp starts at start_value, lasting ramp_time / sample_period ticks (truncated), with
// a per-tick step of (target - start_value) / ticks carried with 32 fraction bits; the
// last tick lands exactly on target, and a ramp shorter than one period (or a zero
// period) jumps straight to target. One item is worked at a time and in_stall stays
// high until it is done. A tick with unchanged target passes from the input transfer
// through ST_CHECK to ST_FINISH, which waits while out_stall holds the last result, then
// commits its own result; the next tick can transfer once the sequencer is back in ST_IDLE.
// A target change with a nonzero period runs the shared serial divider, one quotient bit
// per cycle, in ST_CNT for the tick count and then in ST_STEP for the step; a ramp too
// short for one tick skips the step division. The result sits in an output register, so
// the next tick is accepted while it waits. sample_period resets to 1; write it only
// while the block is idle.
module linear_setpoint_ramp
	import lsr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [TIME_W-1:0]        cfg_data,
	// input ticks
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [VAL_W-1:0]  start_value,
	input  wire logic signed [VAL_W-1:0]  target,
	input  wire logic [TIME_W-1:0]        ramp_time,
	// results
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [VAL_W-1:0]       ramp_value
);

	lsr_state_t state_q, state_next;

	logic [TIME_W-1:0]        sample_period_q;
	logic [VAL_W-1:0]         last_target_q;
	logic [VAL_W-1:0]         cur_value_q;
	logic [FRAC_W-1:0]        frac_acc_q;
	logic signed [STEP_W-1:0] step_q;
	logic [TIME_W-1:0]        ticks_q;

	logic [VAL_W-1:0]         start_q;
	logic [VAL_W-1:0]         tgt_q;
	logic [TIME_W-1:0]        rtime_q;
	logic signed [DIFF_W-1:0] diff_q;

	logic                     out_valid_q;
	logic [VAL_W-1:0]         ramp_value_q;

	div_cmd_t                 div_cmd;
	logic [DVD_W-1:0]         div_dividend;
	logic [DIV_W-1:0]         div_divisor;
	logic                     div_done;
	logic [DVD_W-1:0]         div_quot;

	logic                     in_xfer;
	logic                     slot_free;
	logic                     commit;
	logic                     tgt_changed;
	logic [TIME_W-1:0]        count;
	logic [DIFF_W-1:0]        diff_mag;
	logic signed [ACC_W-1:0]  acc_sum;
	logic [VAL_W-1:0]         cur_next;
	logic [FRAC_W-1:0]        frac_next;

	assign in_xfer     = in_valid && !in_stall;
	assign slot_free   = !out_valid_q || !out_stall;
	assign tgt_changed = (tgt_q != last_target_q);
	assign count       = div_quot[TIME_W-1:0];
	assign diff_mag    = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				if (tgt_changed && sample_period_q != '0) state_next = ST_CNT;
				else state_next = ST_FINISH;
			end
			ST_CNT: begin
				if (div_done) state_next = (count == '0) ? ST_FINISH : ST_STEP;
			end
			ST_STEP: begin
				if (div_done) state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall     = 1'b1;
		commit       = 1'b0;
		div_cmd      = '{start: 1'b0, iters: CNT_ITERS};
		div_dividend = {rtime_q, {(DVD_W-TIME_W){1'b0}}};
		div_divisor  = sample_period_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_CHECK: begin
				div_cmd.start = tgt_changed && sample_period_q != '0;
			end
			ST_CNT: begin
				div_cmd.start = div_done && count != '0;
				div_cmd.iters = STEP_ITERS;
				div_dividend  = {diff_mag, {FRAC_W{1'b0}}};
				div_divisor   = count;
			end
			ST_STEP: begin
			end
			ST_FINISH: begin
				commit = slot_free;
			end
			default: begin
			end
		endcase
	end

	// One tick of the running value
	always_comb begin
		acc_sum   = $signed({{(ACC_W-VAL_W-FRAC_W){cur_value_q[VAL_W-1]}},
			cur_value_q, frac_acc_q}) + ACC_W'(step_q);
		cur_next  = cur_value_q;
		frac_next = frac_acc_q;
		if (ticks_q == TIME_W'(1)) begin
			cur_next  = tgt_q;
			frac_next = '0;
		end else if (ticks_q != '0) begin
			cur_next  = acc_sum[VAL_W+FRAC_W-1:FRAC_W];
			frac_next = acc_sum[FRAC_W-1:0];
		end
	end

	lsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Control state, configuration and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			sample_period_q <= SAMPLE_PERIOD_RST;
			last_target_q   <= '0;
			cur_value_q     <= '0;
			frac_acc_q      <= '0;
			step_q          <= '0;
			ticks_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) sample_period_q <= cfg_data;

			// new ramp setup
			if (state_q == ST_CHECK && tgt_changed) begin
				last_target_q <= tgt_q;
				frac_acc_q    <= '0;
				if (sample_period_q == '0) begin
					cur_value_q <= tgt_q;
					ticks_q     <= '0;
					step_q      <= '0;
				end else begin
					cur_value_q <= start_q;
				end
			end
			if (state_q == ST_CNT && div_done) begin
				ticks_q <= count;
				if (count == '0) begin
					cur_value_q <= tgt_q;
					step_q      <= '0;
				end
			end
			if (state_q == ST_STEP && div_done) begin
				step_q <= diff_q[DIFF_W-1] ? -$signed(div_quot) : $signed(div_quot);
			end

			// tick update and result register
			if (commit) begin
				cur_value_q <= cur_next;
				frac_acc_q  <= frac_next;
				if (ticks_q != '0) ticks_q <= ticks_q - TIME_W'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item operands and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			start_q <= start_value;
			tgt_q   <= target;
			rtime_q <= ramp_time;
		end
		if (state_q == ST_CHECK) begin
			diff_q <= $signed({tgt_q[VAL_W-1], tgt_q}) - $signed({start_q[VAL_W-1], start_q});
		end
		if (commit) ramp_value_q <= cur_next;
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign ramp_value = ramp_value_q;

	// Checks
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result appeared outside the finish step");

	a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_CNT || state_q == ST_STEP))
		else $error("divider finished while sequencer not waiting");

	a_last_tick_on_target: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && ticks_q == TIME_W'(1)) |=> (cur_value_q == last_target_q))
		else $error("ramp did not land on target");

	a_ticks_zero_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && ticks_q == '0) |=> (cur_value_q == $past(cur_value_q)))
		else $error("value moved with no ramp active");

endmodule

`default_nettype wire

// ===== tb/sv/linear_setpoint_ramp_tb.sv =====
// Testbench for the linear set-point ramp generator: directed and random ticks, checked per transfer.
`default_nettype none

module linear_setpoint_ramp_tb;
	import lsr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [VAL_W-1:0] start;
		logic signed [VAL_W-1:0] tgt;
		logic [TIME_W-1:0]       rtime;
	} tick_t;

	// DUT connections
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [TIME_W-1:0]       cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [VAL_W-1:0] start_value = '0;
	logic signed [VAL_W-1:0] target = '0;
	logic [TIME_W-1:0]       ramp_time = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [VAL_W-1:0] ramp_value;

	// ramp state as the block should hold it
	logic [TIME_W-1:0]       cur_period = SAMPLE_PERIOD_RST;
	logic signed [VAL_W-1:0] prev_target = '0;
	logic signed [VAL_W-1:0] ramp_val = '0;
	longint                  step_q32 = 0;
	logic [TIME_W-1:0]       ticks_rem = '0;
	logic [FRAC_W-1:0]       frac_bits = '0;

	// ticks waiting to be sent, ramp values waiting to come back
	tick_t                   tick_q[$];
	logic signed [VAL_W-1:0] ramp_exp_q[$];
	tick_t                   drv_tick;
	logic signed [VAL_W-1:0] want;

	// run bookkeeping
	int  n_queued = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_errors = 0;
	int  n_writes = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  gap_pct = 0;
	int  stall_pct = 0;
	logic signed [VAL_W-1:0] plan_last = '0;

	linear_setpoint_ramp u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_value(start_value),
		.target     (target),
		.ramp_time  (ramp_time),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ramp_value (ramp_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Advance the ramp by one tick and return the value it should output
	function automatic logic signed [VAL_W-1:0] ramp_predict(tick_t t);
		logic [TIME_W-1:0] n_ticks;
		longint            span;
		longint            acc;
		if (t.tgt != prev_target) begin
			n_ticks = (cur_period == 0) ? '0 : t.rtime / cur_period;
			prev_target = t.tgt;
			ramp_val = t.start;
			frac_bits = '0;
			if (n_ticks == 0) begin
				// too short to divide: jump to target
				ramp_val = t.tgt;
				ticks_rem = '0;
				step_q32 = 0;
			end else begin
				span = longint'(t.tgt) - longint'(t.start);
				step_q32 = (span * 65536) / longint'({48'd0, n_ticks});
				ticks_rem = n_ticks;
			end
		end
		if (ticks_rem != 0) begin
			if (ticks_rem == 1) begin
				// last tick lands exactly
				ramp_val = t.tgt;
				frac_bits = '0;
			end else begin
				acc = longint'(ramp_val) * 65536 + longint'({48'd0, frac_bits}) + step_q32;
				ramp_val = acc[47:16];
				frac_bits = acc[15:0];
			end
			ticks_rem = ticks_rem - 1'b1;
		end
		return ramp_val;
	endfunction

	task automatic push_tick(input logic signed [VAL_W-1:0] s, input logic signed [VAL_W-1:0] t,
			input logic [TIME_W-1:0] r);
		tick_t x;
		x.start = s;
		x.tgt = t;
		x.rtime = r;
		tick_q.push_back(x);
		n_queued++;
		plan_last = t;
	endtask

	// Wait until every tick is sent and every ramp value is back, then settle
	task automatic wait_drained();
		while (n_sent != n_queued || n_checked != n_sent)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_period(input logic [TIME_W-1:0] val);
		wait_drained();
		@(posedge clk);
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cur_period = val;
		n_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Mostly complete ramps with random content, plus stray ticks and cut-off ramps
	task automatic random_phase(input int n_items);
		int made;
		int cnt;
		int maxc;
		int hi;
		int extra;
		logic [TIME_W-1:0]       rt;
		logic signed [VAL_W-1:0] tg;
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(0, 99) < 80) begin
				do tg = $urandom; while (tg == plan_last);
				if (cur_period == 0) begin
					cnt = $urandom_range(1, 3);
					rt = 16'($urandom);
				end else begin
					maxc = 65535 / cur_period;
					if (maxc > 24)
						maxc = 24;
					cnt = $urandom_range(1, maxc);
					hi = 65535 - cnt * cur_period;
					if (hi > cur_period - 1)
						hi = cur_period - 1;
					rt = 16'(cnt * cur_period + $urandom_range(0, hi));
				end
				push_tick($urandom, tg, rt);
				made++;
				extra = cnt - 1 + $urandom_range(0, 3);
				if ($urandom_range(0, 9) == 0)
					extra = $urandom_range(0, extra);
				repeat (extra) begin
					push_tick($urandom, tg, 16'($urandom));
					made++;
				end
			end else begin
				tg = $urandom_range(0, 1) ? $urandom : plan_last;
				push_tick($urandom, tg, 16'($urandom));
				made++;
			end
		end
	endtask

	// Driver: take ticks from the queue, hold while stalled, insert idle bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				ramp_exp_q.push_back(ramp_predict(drv_tick));
				n_sent++;
			end
			if (in_valid && in_stall) begin
				// stalled transfer holds its payload
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				drv_tick = tick_q.pop_front();
				in_valid <= 1'b1;
				start_value <= drv_tick.start;
				target <= drv_tick.tgt;
				ramp_time <= drv_tick.rtime;
				if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
					gap_left = $urandom_range(1, 12);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each ramp value transfer, drive stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (ramp_exp_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected ramp_value %h with nothing pending", ramp_value);
				end else begin
					want = ramp_exp_q.pop_front();
					if (ramp_value !== want) begin
						n_errors++;
						if (n_errors <= 10)
							$display("ramp_value mismatch on tick %0d: expected %h, got %h",
								n_checked, want, ramp_value);
					end
					n_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset period of 1: unchanged zero target, full-scale ramps both ways
		gap_pct = 10;
		stall_pct = 10;
		push_tick(32'sh1234_5678, 32'sh0000_0000, 16'd100);
		push_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd4);
		repeat (4) push_tick($urandom, 32'sh7FFF_FFFF, 16'($urandom));
		push_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'd3);
		repeat (2) push_tick($urandom, 32'sh8000_0000, 16'($urandom));
		// zero ramp time jumps
		push_tick(32'sh0000_0000, 32'sh0001_8000, 16'd0);
		// small negative step with fractional truncation
		push_tick(32'sh0000_000A, 32'shFFFF_FFFD, 16'd5);
		push_tick($urandom, 32'shFFFF_FFFD, 16'($urandom));
		// new target in the middle of a ramp
		push_tick(32'sh0001_0000, 32'sh0005_0000, 16'd10);
		push_tick($urandom, 32'sh0005_0000, 16'($urandom));
		push_tick(32'sh0003_0000, 32'shFFFE_0000, 16'd2);
		push_tick($urandom, 32'shFFFE_0000, 16'($urandom));
		// longest tick count
		push_tick(32'sh0000_0000, 32'sh7FFF_0000, 16'hFFFF);
		push_tick($urandom, 32'sh7FFF_0000, 16'($urandom));

		// zero period: every new target jumps
		write_period(16'd0);
		push_tick(32'sh0100_0000, 32'sh0200_0000, 16'hFFFF);
		push_tick($urandom, 32'sh0200_0000, 16'd40);

		// largest period: one tick at most
		write_period(16'hFFFF);
		push_tick(32'sh0000_0000, 32'sh0300_0000, 16'hFFFE);
		push_tick(32'sh1000_0000, 32'shF000_0000, 16'hFFFF);
		push_tick($urandom, 32'shF000_0000, 16'($urandom));

		// odd period around the divide boundary
		write_period(16'd7);
		push_tick(32'sh0000_0000, 32'sh0000_1000, 16'd6);
		push_tick(32'sh0000_0000, 32'sh0000_2000, 16'd7);
		push_tick(32'sh0000_0000, 32'sh0000_3001, 16'd20);
		push_tick($urandom, 32'sh0000_3001, 16'($urandom));

		// random phases over a spread of periods
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: write_period(16'd1);
				1: write_period(16'd2);
				2: write_period(16'($urandom_range(3, 16)));
				3: write_period(16'($urandom_range(17, 65534)));
				4: write_period(16'd0);
				5: write_period(16'hFFFF);
				6: write_period(16'($urandom_range(1, 65535)));
				default: write_period(16'($urandom_range(1, 8)));
			endcase
			if (p == 7) begin
				// closing stretch runs at full rate
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 8;
					default: gap_pct = 25;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 8;
					default: stall_pct = 25;
				endcase
			end
			random_phase(140);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("sent %0d ticks across %0d sample period settings (zero and full scale included)",
			n_sent, n_writes + 1);
		$display("checked %0d ramp values, %0d mismatches, %0d left pending",
			n_checked, n_errors, ramp_exp_q.size());
		if (n_errors == 0 && ramp_exp_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== linear_setpoint_ramp.f =====
rtl/lsr_pkg.sv
rtl/lsr_div.sv
rtl/linear_setpoint_ramp.sv
tb/sv/linear_setpoint_ramp_tb.sv
